// File: rtl/core/vkce_pkg.sv
// Types and constants for the keymap configuration command engine.
`timescale 1ns / 1ps
package vkce_pkg;

  localparam int PKT_BYTES  = 32;
  localparam int WINDOW_MAX = 28;

  localparam logic [7:0] CMD_PROTOCOL   = 8'h01;
  localparam logic [7:0] CMD_VALUE_GET  = 8'h02;
  localparam logic [7:0] CMD_VALUE_SET  = 8'h03;
  localparam logic [7:0] CMD_KEY_GET    = 8'h04;
  localparam logic [7:0] CMD_KEY_SET    = 8'h05;
  localparam logic [7:0] CMD_RESET_A    = 8'h06;
  localparam logic [7:0] CMD_RESET_B    = 8'h0A;
  localparam logic [7:0] CMD_MACRO_CNT  = 8'h0C;
  localparam logic [7:0] CMD_MACRO_SIZE = 8'h0D;
  localparam logic [7:0] CMD_MACRO_GET  = 8'h0E;
  localparam logic [7:0] CMD_MACRO_SET  = 8'h0F;
  localparam logic [7:0] CMD_MACRO_RST  = 8'h10;
  localparam logic [7:0] CMD_LAYER_CNT  = 8'h11;
  localparam logic [7:0] CMD_BUF_GET    = 8'h12;
  localparam logic [7:0] CMD_BUF_SET    = 8'h13;
  localparam logic [7:0] CMD_UNHANDLED  = 8'hFF;

  localparam logic [7:0] VAL_UPTIME   = 8'h01;
  localparam logic [7:0] VAL_LAYOUT   = 8'h02;
  localparam logic [7:0] VAL_FIRMWARE = 8'h04;
  localparam logic [7:0] VAL_ACK      = 8'h05;
  localparam logic [7:0] VAL_SAVE     = 8'hFF;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [2:0] REG_ADDR_PROTOCOL = 3'd0;
  localparam logic [2:0] REG_ADDR_FIRMWARE = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [63:0] chunk_data;
    logic [3:0]  chunk_len;
    logic [31:0] uptime_ms;
  } vkce_in_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [63:0] reply_data;
    logic        keymap_dirty;
    logic        save_request;
    logic        default_reset_request;
    logic        activity;
  } vkce_out_t;

endpackage

// File: rtl/core/via_keymap_command_engine.sv
// Keymap configuration command engine: command assembly, execution and reply.
`timescale 1ns / 1ps
// An OUT chunk or IN poll that completes no command leaves the engine idle, and the next one
// is taken unless out_stall holds the last beat. A completing chunk goes through execute and
// finish; a keycode get adds read and use states, and a window get or set reads then uses each
// byte in turn through the keymap memory, up to 28 bytes. After reset the memory is swept to
// zero, one entry a cycle over all LAYER_COUNT*ROW_COUNT*COL_COUNT entries, before any item is taken.
module via_keymap_command_engine #(
  parameter int LAYER_COUNT = 4,
  parameter int ROW_COUNT   = 8,
  parameter int COL_COUNT   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vkce_pkg::vkce_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vkce_pkg::vkce_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import vkce_pkg::*;

  localparam int CELLS  = LAYER_COUNT * ROW_COUNT * COL_COUNT;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_EXEC  = 8'b0000_0100,
    S_KRD   = 8'b0000_1000,
    S_KUSE  = 8'b0001_0000,
    S_WRD   = 8'b0010_0000,
    S_WUSE  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    RS_IDLE  = 3'b001,
    RS_ARMED = 3'b010,
    RS_SEND  = 3'b100
  } reply_t;

  state_t      state_r;
  reply_t      rs_r;
  logic [2:0]  chunk_r;
  logic [5:0]  pos_r;
  logic [7:0]  buf_r [PKT_BYTES];
  logic [31:0] layout_r;
  logic [15:0] proto_r;
  logic [31:0] fw_r;
  logic [31:0] uptime_r;
  logic [4:0]  win_i_r;
  logic        dirty_r;
  logic        save_r;
  logic        dflt_r;
  logic [CELL_W-1:0] clr_r;
  logic        out_valid_r;
  vkce_out_t   out_data_r;

  logic [15:0] km_mem [CELLS];
  logic [15:0] km_rdata_r;
  logic        km_we;
  logic [CELL_W-1:0] km_waddr;
  logic [CELL_W-1:0] km_raddr;
  logic [15:0] km_wdata;

  logic        accept;
  logic        cfg_wr;
  logic [3:0]  take;
  logic [6:0]  pos_end;
  logic        complete;
  logic        cell_ok;
  logic [CELL_W-1:0] cell_idx;
  logic [15:0] woff;
  logic [14:0] wcell;
  logic        wvalid;
  logic [4:0]  win_n;
  logic [4:0]  win_b;
  logic [7:0]  wbyte;
  logic        poll_send;
  logic [2:0]  poll_ch;
  logic [63:0] poll_data;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign prdata    = paddr[2] ? fw_r : {16'd0, proto_r};
  assign in_stall  = (state_r != S_IDLE) | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign take     = (in_data.chunk_len > 4'd8) ? 4'd8 : in_data.chunk_len;
  assign pos_end  = ((7'(pos_r) + 7'(take)) > 7'(PKT_BYTES)) ? 7'(PKT_BYTES)
                                                             : 7'(pos_r) + 7'(take);
  assign complete = (pos_end >= 7'(PKT_BYTES)) | (in_data.chunk_len < 4'd8);

  assign cell_ok  = (32'(buf_r[1]) < LAYER_COUNT) && (32'(buf_r[2]) < ROW_COUNT) &&
                    (32'(buf_r[3]) < COL_COUNT);
  assign cell_idx = CELL_W'((32'(buf_r[1]) * ROW_COUNT + 32'(buf_r[2])) * COL_COUNT +
                            32'(buf_r[3]));

  assign woff   = {buf_r[1], buf_r[2]} + 16'(win_i_r);
  assign wcell  = woff[15:1];
  assign wvalid = 32'(wcell) < CELLS;
  assign win_n  = (buf_r[3] > 8'(WINDOW_MAX)) ? 5'(WINDOW_MAX) : buf_r[3][4:0];
  assign win_b  = 5'd4 + win_i_r;
  assign wbyte  = !wvalid ? 8'd0 : (woff[0] ? km_rdata_r[7:0] : km_rdata_r[15:8]);

  assign poll_send = (rs_r == RS_ARMED) | (rs_r == RS_SEND);
  assign poll_ch   = (rs_r == RS_ARMED) ? 3'd0 : chunk_r;
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      poll_data[8*j +: 8] = buf_r[{poll_ch[1:0], 3'(j)}];
    end
  end

  always_comb begin
    km_we    = 1'b0;
    km_waddr = clr_r;
    km_wdata = 16'd0;
    km_raddr = (state_r == S_KRD) ? cell_idx : wcell[CELL_W-1:0];
    unique case (state_r)
      S_CLEAR: km_we = 1'b1;
      S_EXEC: begin
        km_we    = (buf_r[0] == CMD_KEY_SET) & cell_ok;
        km_waddr = cell_idx;
        km_wdata = {buf_r[4], buf_r[5]};
      end
      S_WUSE: begin
        km_we    = (buf_r[0] == CMD_BUF_SET) & wvalid;
        km_waddr = wcell[CELL_W-1:0];
        km_wdata = woff[0] ? {km_rdata_r[15:8], buf_r[win_b]}
                           : {buf_r[win_b], km_rdata_r[7:0]};
      end
      default: km_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (km_we) begin
      km_mem[km_waddr] <= km_wdata;
    end
    km_rdata_r <= km_mem[km_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rs_r        <= RS_IDLE;
      chunk_r     <= 3'd0;
      pos_r       <= 6'd0;
      layout_r    <= 32'd0;
      proto_r     <= 16'd12;
      fw_r        <= 32'd0;
      uptime_r    <= 32'd0;
      win_i_r     <= 5'd0;
      dirty_r     <= 1'b0;
      save_r      <= 1'b0;
      dflt_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      for (int k = 0; k < PKT_BYTES; k++) begin
        buf_r[k] <= 8'd0;
      end
    end else begin
      if (cfg_wr && paddr == REG_ADDR_PROTOCOL) proto_r <= pwdata[15:0];
      if (cfg_wr && paddr == REG_ADDR_FIRMWARE) fw_r <= pwdata;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == CELLS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            out_data_r  <= '0;
            out_valid_r <= 1'b1;
            dirty_r     <= 1'b0;
            save_r      <= 1'b0;
            dflt_r      <= 1'b0;
            uptime_r    <= in_data.uptime_ms;
            if (in_data.mode) begin
              if (!poll_send) begin
                out_data_r.reply_kind <= KIND_EMPTY;
              end else if (poll_ch >= 3'd4) begin
                rs_r <= RS_IDLE;
                out_data_r.reply_kind <= KIND_EMPTY;
              end else begin
                rs_r    <= RS_SEND;
                chunk_r <= poll_ch + 3'd1;
                out_data_r.reply_kind <= KIND_DATA;
                out_data_r.reply_data <= poll_data;
              end
            end else if (rs_r != RS_ARMED) begin
              rs_r <= RS_IDLE;
              for (int j = 0; j < 8; j++) begin
                if (4'(j) < take && (7'(pos_r) + 7'(j)) < 7'(PKT_BYTES)) begin
                  buf_r[5'(pos_r + 6'(j))] <= in_data.chunk_data[8*j +: 8];
                end
              end
              pos_r <= complete ? 6'd0 : pos_end[5:0];
              if (complete) begin
                out_valid_r <= 1'b0;
                state_r     <= S_EXEC;
              end
            end
          end
        end
        S_EXEC: begin
          win_i_r <= 5'd0;
          state_r <= S_FIN;
          case (buf_r[0])
            CMD_PROTOCOL: begin
              buf_r[1] <= proto_r[15:8];
              buf_r[2] <= proto_r[7:0];
            end
            CMD_VALUE_GET: begin
              if (buf_r[1] == VAL_UPTIME) begin
                {buf_r[2], buf_r[3], buf_r[4], buf_r[5]} <= uptime_r;
              end else if (buf_r[1] == VAL_LAYOUT) begin
                {buf_r[2], buf_r[3], buf_r[4], buf_r[5]} <= layout_r;
              end else if (buf_r[1] == VAL_FIRMWARE) begin
                {buf_r[2], buf_r[3], buf_r[4], buf_r[5]} <= fw_r;
              end else begin
                buf_r[0] <= CMD_UNHANDLED;
              end
            end
            CMD_VALUE_SET: begin
              if (buf_r[1] == VAL_LAYOUT) begin
                layout_r <= {buf_r[2], buf_r[3], buf_r[4], buf_r[5]};
              end else if (buf_r[1] == VAL_SAVE) begin
                save_r <= 1'b1;
              end else if (buf_r[1] != VAL_ACK) begin
                buf_r[0] <= CMD_UNHANDLED;
              end
            end
            CMD_KEY_GET: state_r <= S_KRD;
            CMD_KEY_SET: dirty_r <= cell_ok;
            CMD_RESET_A, CMD_RESET_B: begin
              dflt_r  <= 1'b1;
              dirty_r <= 1'b1;
            end
            CMD_MACRO_CNT: buf_r[1] <= 8'd0;
            CMD_MACRO_SIZE: begin
              buf_r[1] <= 8'd0;
              buf_r[2] <= 8'd0;
            end
            CMD_MACRO_GET: begin
              for (int k = 0; k < WINDOW_MAX; k++) begin
                if (5'(k) < win_n) buf_r[4 + k] <= 8'd0;
              end
            end
            CMD_MACRO_SET, CMD_MACRO_RST: state_r <= S_FIN;
            CMD_LAYER_CNT: buf_r[1] <= 8'(LAYER_COUNT);
            CMD_BUF_GET: state_r <= S_WRD;
            CMD_BUF_SET: begin
              dirty_r <= 1'b1;
              state_r <= S_WRD;
            end
            default: buf_r[0] <= CMD_UNHANDLED;
          endcase
        end
        S_KRD: state_r <= S_KUSE;
        S_KUSE: begin
          buf_r[4] <= cell_ok ? km_rdata_r[15:8] : 8'd0;
          buf_r[5] <= cell_ok ? km_rdata_r[7:0] : 8'd0;
          state_r  <= S_FIN;
        end
        S_WRD: state_r <= (win_i_r == win_n) ? S_FIN : S_WUSE;
        S_WUSE: begin
          if (buf_r[0] == CMD_BUF_GET) buf_r[win_b] <= wbyte;
          win_i_r <= win_i_r + 5'd1;
          state_r <= S_WRD;
        end
        S_FIN: begin
          rs_r        <= RS_ARMED;
          out_valid_r <= 1'b1;
          out_data_r  <= '0;
          out_data_r.keymap_dirty          <= dirty_r;
          out_data_r.save_request          <= save_r;
          out_data_r.default_reset_request <= dflt_r;
          out_data_r.activity              <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fin_arms: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> rs_r == RS_ARMED && out_valid_r && out_data_r.activity)
    else $error("finished command did not arm a reply");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < 6'(PKT_BYTES))
    else $error("receive position out of range");

  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    win_i_r <= 5'(WINDOW_MAX))
    else $error("window counter overran");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> $past(state_r) == S_IDLE && !out_valid_r)
    else $error("command started outside idle");

endmodule

// File: sim/tb_via_keymap_command_engine.sv
// Testbench for the keymap configuration command engine: directed and random command traffic.
`timescale 1ns / 1ps
module tb_via_keymap_command_engine;
  import vkce_pkg::*;

  localparam int LAYERS = 4;
  localparam int ROWS = 8;
  localparam int COLS = 16;
  localparam int CELLS = LAYERS * ROWS * COLS;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum logic [1:0] {RS_IDLE = 2'd0, RS_ARMED = 2'd1, RS_SENDING = 2'd2} reply_st_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vkce_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  vkce_out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  via_keymap_command_engine dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [15:0] m_proto;
  logic [31:0] m_fw;
  logic [7:0] m_buf [0:31];
  int m_pos;
  reply_st_t m_rs;
  int m_chunk;
  logic [31:0] m_layout;
  logic [15:0] m_keys [0:CELLS-1];

  vkce_out_t replies_due[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit rx_random = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void put32(int at, logic [31:0] v);
    m_buf[at] = v[31:24]; m_buf[at+1] = v[23:16]; m_buf[at+2] = v[15:8]; m_buf[at+3] = v[7:0];
  endfunction

  function automatic logic [7:0] win_rd(logic [15:0] off);
    int c;
    c = off >> 1;
    if (c >= CELLS) return 8'h00;
    return off[0] ? m_keys[c][7:0] : m_keys[c][15:8];
  endfunction

  function automatic void win_wr(logic [15:0] off, logic [7:0] v);
    int c;
    c = off >> 1;
    if (c >= CELLS) return;
    if (off[0]) m_keys[c][7:0] = v;
    else m_keys[c][15:8] = v;
  endfunction

  function automatic void run_command(ref vkce_out_t r);
    logic [15:0] off, kc;
    int n, kidx;
    bit ok;
    off = {m_buf[1], m_buf[2]};
    n = (m_buf[3] > WINDOW_MAX) ? WINDOW_MAX : m_buf[3];
    ok = (m_buf[1] < LAYERS) && (m_buf[2] < ROWS) && (m_buf[3] < COLS);
    kidx = (m_buf[1] * ROWS + m_buf[2]) * COLS + m_buf[3];
    case (m_buf[0])
      CMD_PROTOCOL: begin
        m_buf[1] = m_proto[15:8]; m_buf[2] = m_proto[7:0];
      end
      CMD_VALUE_GET: begin
        if (m_buf[1] == VAL_LAYOUT) put32(2, m_layout);
        else if (m_buf[1] == VAL_FIRMWARE) put32(2, m_fw);
        else if (m_buf[1] != VAL_UPTIME) m_buf[0] = CMD_UNHANDLED;
      end
      CMD_VALUE_SET: begin
        if (m_buf[1] == VAL_LAYOUT) m_layout = {m_buf[2], m_buf[3], m_buf[4], m_buf[5]};
        else if (m_buf[1] == VAL_SAVE) r.save_request = 1'b1;
        else if (m_buf[1] != VAL_ACK) m_buf[0] = CMD_UNHANDLED;
      end
      CMD_KEY_GET: begin
        kc = ok ? m_keys[kidx] : 16'h0;
        m_buf[4] = kc[15:8]; m_buf[5] = kc[7:0];
      end
      CMD_KEY_SET: begin
        if (ok) begin
          m_keys[kidx] = {m_buf[4], m_buf[5]};
          r.keymap_dirty = 1'b1;
        end
      end
      CMD_RESET_A, CMD_RESET_B: begin
        r.default_reset_request = 1'b1; r.keymap_dirty = 1'b1;
      end
      CMD_MACRO_CNT: m_buf[1] = 8'h00;
      CMD_MACRO_SIZE: begin
        m_buf[1] = 8'h00; m_buf[2] = 8'h00;
      end
      CMD_MACRO_GET: for (int i = 0; i < n; i++) m_buf[4+i] = 8'h00;
      CMD_MACRO_SET, CMD_MACRO_RST: ;
      CMD_LAYER_CNT: m_buf[1] = 8'(LAYERS);
      CMD_BUF_GET: for (int i = 0; i < n; i++) m_buf[4+i] = win_rd(off + i[15:0]);
      CMD_BUF_SET: begin
        for (int i = 0; i < n; i++) win_wr(off + i[15:0], m_buf[4+i]);
        r.keymap_dirty = 1'b1;
      end
      default: m_buf[0] = CMD_UNHANDLED;
    endcase
  endfunction

  function automatic vkce_out_t predict_reply(vkce_in_t it);
    vkce_out_t r;
    int take;
    r = '0;
    if (!it.mode) begin
      if (m_rs != RS_ARMED) begin
        take = (it.chunk_len > 8) ? 8 : it.chunk_len;
        m_rs = RS_IDLE;
        for (int i = 0; i < take && m_pos < PKT_BYTES; i++) begin
          m_buf[m_pos] = it.chunk_data[8*i +: 8];
          m_pos++;
        end
        if (m_pos >= PKT_BYTES || it.chunk_len < 8) begin
          m_pos = 0;
          if (m_buf[0] == CMD_VALUE_GET && m_buf[1] == VAL_UPTIME) put32(2, it.uptime_ms);
          run_command(r);
          if (m_buf[0] == CMD_VALUE_GET && m_buf[1] == VAL_UPTIME) put32(2, it.uptime_ms);
          m_rs = RS_ARMED;
          r.activity = 1'b1;
        end
      end
    end else begin
      if (m_rs == RS_ARMED) begin
        m_chunk = 0; m_rs = RS_SENDING;
      end
      if (m_rs != RS_SENDING) r.reply_kind = KIND_EMPTY;
      else if (m_chunk >= 4) begin
        m_rs = RS_IDLE; r.reply_kind = KIND_EMPTY;
      end else begin
        for (int i = 0; i < 8; i++) r.reply_data[8*i +: 8] = m_buf[m_chunk*8 + i];
        m_chunk++;
        r.reply_kind = KIND_DATA;
      end
    end
    return r;
  endfunction

  task automatic send_beat(vkce_in_t it);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(predict_reply(it));
  endtask

  task automatic send_chunk(logic [63:0] d, logic [3:0] len);
    vkce_in_t it;
    it.mode = 1'b0; it.chunk_data = d; it.chunk_len = len; it.uptime_ms = $urandom;
    send_beat(it);
  endtask

  task automatic send_poll();
    vkce_in_t it;
    it.mode = 1'b1; it.chunk_data = {$urandom, $urandom}; it.chunk_len = 4'($urandom);
    it.uptime_ms = $urandom;
    send_beat(it);
  endtask

  // send a full 32-byte command as four chunks then read all five reply beats
  task automatic send_command(logic [7:0] b [0:31], logic [31:0] up);
    vkce_in_t it;
    for (int c = 0; c < 4; c++) begin
      it.mode = 1'b0; it.chunk_len = 4'd8; it.uptime_ms = up;
      for (int i = 0; i < 8; i++) it.chunk_data[8*i +: 8] = b[c*8+i];
      send_beat(it);
    end
    repeat (5) send_poll();
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == REG_ADDR_PROTOCOL) m_proto = v[15:0];
    else m_fw = v;
  endtask

  function automatic void rand_cmd(ref logic [7:0] b [0:31]);
    logic [7:0] ops [0:17];
    ops = '{CMD_PROTOCOL, CMD_VALUE_GET, CMD_VALUE_SET, CMD_KEY_GET, CMD_KEY_SET, CMD_RESET_A,
            CMD_RESET_B, CMD_MACRO_CNT, CMD_MACRO_SIZE, CMD_MACRO_GET, CMD_MACRO_SET,
            CMD_MACRO_RST, CMD_LAYER_CNT, CMD_BUF_GET, CMD_BUF_SET, CMD_BUF_GET, CMD_BUF_SET,
            8'h00};
    for (int i = 0; i < 32; i++) b[i] = 8'($urandom);
    b[0] = ops[$urandom_range(0, 17)];
    if (b[0] == 8'h00) b[0] = 8'($urandom);
    case ($urandom_range(0, 3))
      0: b[1] = 8'($urandom);
      default: b[1] = 8'($urandom_range(0, 5));
    endcase
    if (b[0] == CMD_VALUE_SET && $urandom_range(0, 3) == 0) b[1] = VAL_SAVE;
    if (b[0] == CMD_KEY_GET || b[0] == CMD_KEY_SET) begin
      if ($urandom_range(0, 7) != 0) begin
        b[1] = 8'($urandom_range(0, LAYERS-1)); b[2] = 8'($urandom_range(0, ROWS-1));
        b[3] = 8'($urandom_range(0, COLS-1));
      end
    end
    if (b[0] == CMD_BUF_GET || b[0] == CMD_BUF_SET) begin
      if ($urandom_range(0, 7) != 0) begin
        b[1] = 8'($urandom_range(0, 3)); b[2] = 8'($urandom);
      end
      b[3] = 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8));
    end
  endfunction

  task automatic test_directed();
    logic [7:0] b [0:31];
    for (int i = 0; i < 32; i++) b[i] = 8'h00;
    b[0] = CMD_PROTOCOL; send_command(b, 32'h0);
    b[0] = CMD_VALUE_GET; b[1] = VAL_UPTIME; send_command(b, 32'hFFFF_FFFF);
    b[1] = VAL_FIRMWARE; send_command(b, 32'h0);
    b[0] = CMD_VALUE_SET; b[1] = VAL_LAYOUT; b[2] = 8'hDE; b[3] = 8'hAD; b[4] = 8'hBE;
    b[5] = 8'hEF; send_command(b, 32'h0);
    b[0] = CMD_VALUE_GET; b[1] = VAL_LAYOUT; send_command(b, 32'h0);
    b[1] = 8'h03; send_command(b, 32'h0);
    b[0] = CMD_KEY_SET; b[1] = 8'd3; b[2] = 8'd7; b[3] = 8'd15; b[4] = 8'hFF; b[5] = 8'hFF;
    send_command(b, 32'h0);
    b[0] = CMD_KEY_GET; send_command(b, 32'h0);
    b[1] = 8'd4; send_command(b, 32'h0);
    b[0] = CMD_BUF_SET; b[1] = 8'h03; b[2] = 8'hF8; b[3] = 8'hFF;
    for (int i = 4; i < 32; i++) b[i] = 8'(i * 7);
    send_command(b, 32'h0);
    b[0] = CMD_BUF_GET; send_command(b, 32'h0);
    b[1] = 8'hFF; b[2] = 8'hFF; send_command(b, 32'h0);
    // short command, armed-drop, overlong length, abandoned reply
    send_chunk(64'hFFFF_FFFF_FFFF_FF11, 4'd1);
    send_chunk({$urandom, $urandom}, 4'd8);
    send_poll();
    send_chunk(64'h0000_0000_0000_0006, 4'd15);
    send_chunk(64'h0000_0000_0000_0003, 4'd0);
    send_poll();
    send_poll();
    send_chunk(64'hFF_05_03, 4'd3);
    send_poll();
  endtask

  task automatic test_random(int cmds);
    logic [7:0] b [0:31];
    int p, r, k, nch;
    for (int n = 0; n < cmds; n++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        rand_cmd(b);
        send_command(b, $urandom);
      end else if (r < 9) begin
        rand_cmd(b);
        nch = $urandom_range(1, 4);
        for (int c = 0; c < nch; c++) begin
          k = $urandom_range(0, 15);
          p = c * 8;
          send_chunk({b[p+7], b[p+6], b[p+5], b[p+4], b[p+3], b[p+2], b[p+1], b[p]},
                     (c == nch - 1) ? k[3:0] : 4'd8);
        end
        repeat ($urandom_range(0, 6)) send_poll();
      end else begin
        if ($urandom_range(0, 1)) send_poll();
        else send_chunk({$urandom, $urandom}, 4'($urandom));
      end
    end
  endtask

  task automatic test_registers();
    wait_drain();
    write_reg(REG_ADDR_PROTOCOL, 32'hFFFF);
    write_reg(REG_ADDR_FIRMWARE, 32'hFFFF_FFFF);
    test_random(20);
    wait_drain();
    write_reg(REG_ADDR_PROTOCOL, 32'h0);
    write_reg(REG_ADDR_FIRMWARE, 32'h0);
    test_random(20);
    wait_drain();
    write_reg(REG_ADDR_PROTOCOL, $urandom);
    write_reg(REG_ADDR_FIRMWARE, $urandom);
  endtask

  // receive side: random stall runs, checks each beat against the oldest prediction
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_random && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    vkce_out_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          errors++;
        end else begin
          e = replies_due.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_via_keymap_command_engine: errors");
      $finish;
    end
  end

  initial begin
    m_proto = 16'd12; m_fw = '0; m_pos = 0; m_rs = RS_IDLE; m_chunk = 0; m_layout = '0;
    for (int i = 0; i < 32; i++) m_buf[i] = 8'h00;
    for (int i = 0; i < CELLS; i++) m_keys[i] = 16'h0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_registers();
    test_random(30);
    wait_drain();
    if (errors == 0) $display("tb_via_keymap_command_engine: clean");
    else $display("tb_via_keymap_command_engine: errors");
    $finish;
  end

endmodule
